@@ hw/rtl/overwriting_ring_queue_with_browse_macros.svh @@
// Assertion macros shared by the checker of the overwriting ring queue.
`ifndef OVERWRITING_RING_QUEUE_WITH_BROWSE_MACROS_SVH
`define OVERWRITING_RING_QUEUE_WITH_BROWSE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ORQ_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ring queue assertion failed");

// Next-cycle implication, checked outside reset.
`define ORQ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ring queue assertion failed");

`endif

@@ hw/rtl/orq_pkg.sv @@
// Package with sizes, types and operation codes of the overwriting ring queue.
package orq_pkg;

    localparam int DEPTH       = 16;
    localparam int ENTRY_WIDTH = 32;
    localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int CFG_W       = 5;
    localparam int OP_W        = 3;
    localparam int CAP_RESET   = (DEPTH < 16) ? DEPTH : 16;

    typedef logic [IDX_W-1:0]       idx_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [ENTRY_WIDTH-1:0] entry_t;
    typedef logic [OP_W-1:0]        op_t;

    localparam op_t OP_PUSH  = 3'd0;
    localparam op_t OP_POP   = 3'd1;
    localparam op_t OP_OLDER = 3'd2;
    localparam op_t OP_NEWER = 3'd3;
    localparam op_t OP_READ  = 3'd4;

    typedef struct packed {
        logic   en;
        logic   we;
        idx_t   addr;
        entry_t wdata;
    } mem_req_t;

endpackage

@@ hw/rtl/orq_ram.sv @@
// Generic single-port synchronous RAM with a registered read.
module orq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                  clk,
    input  logic                                  en,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                      wdata,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/orq_ctrl.sv @@
// Pointer, count and capacity control with the item sequencer of the ring queue.
module orq_ctrl (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  orq_pkg::op_t                in_op,
    input  orq_pkg::entry_t             in_data,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [orq_pkg::CFG_W-1:0]   cfg_data,
    output orq_pkg::mem_req_t           mem_req,
    input  orq_pkg::entry_t             mem_rdata,
    output logic                        out_valid,
    input  logic                        out_ready,
    output orq_pkg::entry_t             out_data,
    output logic [2:0]                  out_flags
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_OUT  = 2'd2;

    logic [1:0]              state_reg, state_next;
    orq_pkg::idx_t           head_reg, head_next;
    orq_pkg::idx_t           tail_reg, tail_next;
    orq_pkg::idx_t           cursor_reg, cursor_next;
    orq_pkg::cnt_t           count_reg, count_next;
    orq_pkg::cnt_t           cap_reg, cap_next;
    logic [orq_pkg::DEPTH-1:0] valid_reg, valid_next;
    logic                    found_reg, found_next;
    logic                    hit_reg, hit_next;
    logic                    empty_reg, empty_next;
    logic                    full_reg, full_next;
    orq_pkg::entry_t         data_reg, data_next;
    orq_pkg::idx_t           step;
    logic                    accept;

    function automatic orq_pkg::idx_t slot_next(input orq_pkg::idx_t idx,
                                                input orq_pkg::cnt_t cap);
        orq_pkg::cnt_t n;
        begin
            n = orq_pkg::cnt_t'(idx) + orq_pkg::cnt_t'(1);
            slot_next = (n >= cap) ? '0 : orq_pkg::idx_t'(n);
        end
    endfunction

    function automatic orq_pkg::idx_t slot_prev(input orq_pkg::idx_t idx,
                                                input orq_pkg::cnt_t cap);
        orq_pkg::cnt_t p;
        begin
            p = cap - orq_pkg::cnt_t'(1);
            slot_prev = (idx == '0) ? orq_pkg::idx_t'(p) : idx - orq_pkg::idx_t'(1);
        end
    endfunction

    assign in_ready  = (state_reg == ST_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == ST_IDLE);
    assign accept    = in_valid && in_ready;
    assign out_valid = (state_reg == ST_OUT);
    assign out_data  = data_reg;
    assign out_flags = {full_reg, empty_reg, found_reg};

    always_comb
    begin
        state_next  = state_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        cap_next    = cap_reg;
        valid_next  = valid_reg;
        found_next  = found_reg;
        hit_next    = hit_reg;
        empty_next  = empty_reg;
        full_next   = full_reg;
        data_next   = data_reg;
        step        = '0;
        mem_req.en    = 1'b0;
        mem_req.we    = 1'b0;
        mem_req.addr  = '0;
        mem_req.wdata = in_data;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cfg_valid)
                begin
                    if (cfg_data == '0)
                    begin
                        cap_next = orq_pkg::cnt_t'(1);
                    end
                    else if (32'(cfg_data) > 32'(orq_pkg::DEPTH))
                    begin
                        cap_next = orq_pkg::cnt_t'(orq_pkg::DEPTH);
                    end
                    else
                    begin
                        cap_next = orq_pkg::cnt_t'(cfg_data);
                    end
                    head_next   = '0;
                    tail_next   = '0;
                    cursor_next = '0;
                    count_next  = '0;
                end
                else if (accept)
                begin
                    found_next = 1'b0;
                    case (in_op)
                        orq_pkg::OP_PUSH:
                        begin
                            mem_req.en   = 1'b1;
                            mem_req.we   = 1'b1;
                            mem_req.addr = tail_reg;
                            valid_next[tail_reg] = 1'b1;
                            if (count_reg >= cap_reg)
                            begin
                                head_next = slot_next(head_reg, cap_reg);
                            end
                            else
                            begin
                                count_next = count_reg + orq_pkg::cnt_t'(1);
                            end
                            tail_next   = slot_next(tail_reg, cap_reg);
                            cursor_next = slot_next(tail_reg, cap_reg);
                        end
                        orq_pkg::OP_POP:
                        begin
                            if (count_reg != '0)
                            begin
                                mem_req.en   = 1'b1;
                                mem_req.addr = head_reg;
                                found_next   = 1'b1;
                                head_next    = slot_next(head_reg, cap_reg);
                                count_next   = count_reg - orq_pkg::cnt_t'(1);
                            end
                        end
                        orq_pkg::OP_OLDER:
                        begin
                            if (cursor_reg != head_reg)
                            begin
                                step         = slot_prev(cursor_reg, cap_reg);
                                cursor_next  = step;
                                mem_req.en   = 1'b1;
                                mem_req.addr = step;
                                found_next   = 1'b1;
                            end
                        end
                        orq_pkg::OP_NEWER:
                        begin
                            if (cursor_reg != tail_reg)
                            begin
                                step         = slot_next(cursor_reg, cap_reg);
                                cursor_next  = step;
                                mem_req.en   = 1'b1;
                                mem_req.addr = step;
                                found_next   = 1'b1;
                            end
                        end
                        orq_pkg::OP_READ:
                        begin
                            mem_req.en   = 1'b1;
                            mem_req.addr = cursor_reg;
                            found_next   = 1'b1;
                        end
                        default:
                        begin
                            found_next = 1'b0;
                        end
                    endcase
                    hit_next   = valid_reg[mem_req.addr];
                    empty_next = (count_next == '0);
                    full_next  = (count_next == cap_reg);
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                data_next  = (found_reg && hit_reg) ? mem_rdata : '0;
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            head_reg   <= '0;
            tail_reg   <= '0;
            cursor_reg <= '0;
            count_reg  <= '0;
            cap_reg    <= orq_pkg::cnt_t'(orq_pkg::CAP_RESET);
            valid_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
            cap_reg    <= cap_next;
            valid_reg  <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        found_reg <= found_next;
        hit_reg   <= hit_next;
        empty_reg <= empty_next;
        full_reg  <= full_next;
        data_reg  <= data_next;
    end

endmodule

@@ hw/rtl/overwriting_ring_queue_with_browse.sv @@
// Top level of the overwriting ring queue with a browse cursor.
// The block takes one item at a time: an item is accepted in an idle cycle, the entry
// store (a single-port RAM with a registered read) is accessed in that cycle, and the
// result item is presented from the result register after the RAM read and held until
// taken. The next item is accepted in the cycle after the result is taken. The store
// reads as zero at reset through one valid bit per entry; there is no clearing pass.
// A capacity write clears the pointers and the count and keeps the stored entries. A
// capacity write is taken only in an idle cycle and wins over an input item in that
// cycle.
module overwriting_ring_queue_with_browse (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // entry_data
    input  logic [2:0]  s_axis_tuser,  // op
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,  // read_data
    output logic [2:0]  m_axis_tuser,  // found, is_empty, is_full
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data       // capacity
);

    orq_pkg::mem_req_t mem_req;
    orq_pkg::entry_t   mem_rdata;

    orq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_op     (s_axis_tuser),
        .in_data   (s_axis_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .mem_req   (mem_req),
        .mem_rdata (mem_rdata),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_data  (m_axis_tdata),
        .out_flags (m_axis_tuser)
    );

    orq_ram #(
        .WIDTH (orq_pkg::ENTRY_WIDTH),
        .DEPTH (orq_pkg::DEPTH)
    ) u_ram (
        .clk   (clk),
        .en    (mem_req.en),
        .we    (mem_req.we),
        .addr  (mem_req.addr),
        .wdata (mem_req.wdata),
        .rdata (mem_rdata)
    );

endmodule

@@ hw/rtl/orq_checker.sv @@
// Port-level checker of the overwriting ring queue and its bind statement.
`include "overwriting_ring_queue_with_browse_macros.svh"

module orq_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser,
    input logic        cfg_ready
);

    logic        in_take;
    logic        out_miss;
    logic        out_stall;
    logic [34:0] out_word;

    assign in_take   = s_axis_tvalid && s_axis_tready;
    assign out_miss  = m_axis_tvalid && !m_axis_tuser[0];
    assign out_stall = m_axis_tvalid && !m_axis_tready;
    assign out_word  = {m_axis_tuser, m_axis_tdata};

    `ORQ_ASSERT_IMPLY(a_not_found_zero, clk, rst_n, out_miss, m_axis_tdata == 32'd0)
    `ORQ_ASSERT_IMPLY(a_empty_full_excl, clk, rst_n, m_axis_tvalid, !(&m_axis_tuser[2:1]))
    `ORQ_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_take, !s_axis_tready)
    `ORQ_ASSERT_IMPLY(a_one_in_flight, clk, rst_n, m_axis_tvalid, !s_axis_tready && !cfg_ready)
    `ORQ_ASSERT_NEXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(out_word))

endmodule

bind overwriting_ring_queue_with_browse orq_checker u_orq_checker (.*);

@@ dv/overwriting_ring_queue_with_browse_checker.sv @@
// Checker that predicts and compares every result item of the overwriting ring queue.
module overwriting_ring_queue_with_browse_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // entry_data
    input  logic [2:0]  s_axis_tuser,  // op
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,  // read_data
    input  logic [2:0]  m_axis_tuser,  // found, is_empty, is_full
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [4:0]  cfg_data,      // capacity
    output int          mismatches,
    output int          outstanding
);

    typedef logic [orq_pkg::CFG_W-1:0] cap_t;

    typedef struct packed {
        logic            found;
        orq_pkg::entry_t read_data;
        logic            is_empty;
        logic            is_full;
    } queue_reply_t;

    orq_pkg::entry_t  slots [orq_pkg::DEPTH];
    orq_pkg::idx_t    head_idx;
    orq_pkg::idx_t    tail_idx;
    orq_pkg::idx_t    cursor_idx;
    orq_pkg::cnt_t    fill;
    cap_t             cap;
    queue_reply_t     awaited_replies [$];

    function automatic orq_pkg::idx_t next_slot(orq_pkg::idx_t i);
        int n;
        n = int'(i) + 1;
        return (n >= int'(cap)) ? orq_pkg::idx_t'(0) : orq_pkg::idx_t'(n);
    endfunction

    function automatic orq_pkg::idx_t prev_slot(orq_pkg::idx_t i);
        return (i == 0 || int'(i) > int'(cap)) ? orq_pkg::idx_t'(cap - 1)
                                               : orq_pkg::idx_t'(i - 1);
    endfunction

    function automatic queue_reply_t queue_op_outcome(orq_pkg::op_t op,
                                                      orq_pkg::entry_t data);
        queue_reply_t r;
        r = '0;
        case (op)
            orq_pkg::OP_PUSH:
            begin
                slots[tail_idx] = data;
                if (fill >= cap)
                begin
                    head_idx = next_slot(head_idx);
                end
                else
                begin
                    fill = fill + 1'b1;
                end
                tail_idx   = next_slot(tail_idx);
                cursor_idx = tail_idx;
            end
            orq_pkg::OP_POP:
            begin
                if (fill != 0)
                begin
                    r.found     = 1'b1;
                    r.read_data = slots[head_idx];
                    head_idx    = next_slot(head_idx);
                    fill        = fill - 1'b1;
                end
            end
            orq_pkg::OP_OLDER:
            begin
                if (cursor_idx != head_idx)
                begin
                    cursor_idx  = prev_slot(cursor_idx);
                    r.found     = 1'b1;
                    r.read_data = slots[cursor_idx];
                end
            end
            orq_pkg::OP_NEWER:
            begin
                if (cursor_idx != tail_idx)
                begin
                    cursor_idx  = next_slot(cursor_idx);
                    r.found     = 1'b1;
                    r.read_data = slots[cursor_idx];
                end
            end
            orq_pkg::OP_READ:
            begin
                r.found     = 1'b1;
                r.read_data = slots[cursor_idx];
            end
            default:
            begin
            end
        endcase
        r.is_empty = (fill == 0);
        r.is_full  = (fill == cap);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        queue_reply_t got;
        queue_reply_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < orq_pkg::DEPTH; i++)
            begin
                slots[i] = '0;
            end
            head_idx   = '0;
            tail_idx   = '0;
            cursor_idx = '0;
            fill       = '0;
            cap        = cap_t'(orq_pkg::CAP_RESET);
            awaited_replies.delete();
            mismatches = 0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.found     = m_axis_tuser[0];
                got.read_data = m_axis_tdata;
                got.is_empty  = m_axis_tuser[1];
                got.is_full   = m_axis_tuser[2];
                if (awaited_replies.size() == 0)
                begin
                    if (mismatches < 10)
                    begin
                        $display("%0t: unexpected result item found=%0b data=%h empty=%0b full=%0b",
                                 $time, got.found, got.read_data, got.is_empty, got.is_full);
                    end
                    mismatches++;
                end
                else
                begin
                    want = awaited_replies.pop_front();
                    if (got.found !== want.found || got.read_data !== want.read_data ||
                        got.is_empty !== want.is_empty || got.is_full !== want.is_full)
                    begin
                        if (mismatches < 10)
                        begin
                            $display({"%0t: result mismatch, expected ",
                                      "found=%0b data=%h empty=%0b full=%0b"},
                                     $time, want.found, want.read_data,
                                     want.is_empty, want.is_full);
                            $display({"%0t:                  actual   ",
                                      "found=%0b data=%h empty=%0b full=%0b"},
                                     $time, got.found, got.read_data,
                                     got.is_empty, got.is_full);
                        end
                        mismatches++;
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_data == 0)
                begin
                    cap = cap_t'(1);
                end
                else if (int'(cfg_data) > orq_pkg::DEPTH)
                begin
                    cap = cap_t'(orq_pkg::DEPTH);
                end
                else
                begin
                    cap = cfg_data;
                end
                head_idx   = '0;
                tail_idx   = '0;
                cursor_idx = '0;
                fill       = '0;
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                awaited_replies.push_back(
                    queue_op_outcome(orq_pkg::op_t'(s_axis_tuser), s_axis_tdata));
            end
        end
        outstanding = awaited_replies.size();
    end

endmodule

@@ dv/overwriting_ring_queue_with_browse_tb.sv @@
// Testbench top that drives directed and random queue operations and gives the verdict.
module overwriting_ring_queue_with_browse_tb;

    localparam int           CYCLE_LIMIT  = 1000000;
    localparam int           PHASES       = 12;
    localparam int           PHASE_ITEMS  = 150;
    localparam orq_pkg::op_t OP_SPARE_LO  = 3'd5;
    localparam orq_pkg::op_t OP_SPARE_HI  = 3'd7;

    typedef enum int {RX_OPEN, RX_COIN, RX_SPARSE, RX_TOGGLE} rx_mode_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;
    logic [2:0]  s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [4:0]  cfg_data;
    int          mismatches;
    int          outstanding;
    int          cycle_count = 0;
    int          burst_left = 0;

    overwriting_ring_queue_with_browse dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    overwriting_ring_queue_with_browse_checker checker_i (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    initial
    begin
        rx_mode_t mode;
        int       span;
        m_axis_tready = 1'b0;
        forever
        begin
            mode = rx_mode_t'($urandom_range(0, 3));
            span = $urandom_range(20, 200);
            repeat (span)
            begin
                @(negedge clk);
                case (mode)
                    RX_OPEN:   m_axis_tready = 1'b1;
                    RX_COIN:   m_axis_tready = 1'($urandom_range(0, 1));
                    RX_SPARSE: m_axis_tready = ($urandom_range(0, 3) == 0);
                    default:   m_axis_tready = ~m_axis_tready;
                endcase
            end
        end
    end

    task automatic issue_op(orq_pkg::op_t op, orq_pkg::entry_t data);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap != 0)
            begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = op;
        s_axis_tdata  = data;
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
        @(negedge clk);
        burst_left--;
    endtask

    task automatic wait_idle();
        s_axis_tvalid = 1'b0;
        burst_left    = 0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (4) @(negedge clk);
    endtask

    task automatic set_capacity(logic [4:0] value);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_data  = value;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic orq_pkg::entry_t random_entry();
        case ($urandom_range(0, 15))
            0:       return '0;
            1:       return '1;
            default: return orq_pkg::entry_t'($urandom());
        endcase
    endfunction

    function automatic orq_pkg::op_t random_op(int push_pct);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < push_pct)
        begin
            return orq_pkg::OP_PUSH;
        end
        roll = $urandom_range(0, 99);
        if (roll < 30)
        begin
            return orq_pkg::OP_POP;
        end
        else if (roll < 55)
        begin
            return orq_pkg::OP_OLDER;
        end
        else if (roll < 80)
        begin
            return orq_pkg::OP_NEWER;
        end
        else if (roll < 93)
        begin
            return orq_pkg::OP_READ;
        end
        return orq_pkg::op_t'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    endfunction

    initial
    begin
        int         cap_plan [PHASES];
        logic [4:0] cap_value;
        int         push_pct;
        cap_plan      = '{16, 1, 31, 2, 0, 17, 3, 8, 16, 5, 12, 1};
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        issue_op(orq_pkg::OP_READ, '0);
        issue_op(orq_pkg::OP_POP, '0);
        issue_op(orq_pkg::OP_OLDER, '0);
        issue_op(orq_pkg::OP_NEWER, '1);
        issue_op(orq_pkg::OP_PUSH, '0);
        issue_op(orq_pkg::OP_PUSH, '1);
        issue_op(orq_pkg::OP_PUSH, 32'h5a5a_c3c3);
        repeat (4) issue_op(orq_pkg::OP_OLDER, random_entry());
        repeat (4) issue_op(orq_pkg::OP_NEWER, random_entry());
        issue_op(orq_pkg::OP_POP, '0);
        issue_op(OP_SPARE_HI, '1);
        issue_op(OP_SPARE_LO, random_entry());

        set_capacity(5'd0);
        issue_op(orq_pkg::OP_PUSH, random_entry());
        issue_op(orq_pkg::OP_PUSH, random_entry());
        issue_op(orq_pkg::OP_OLDER, '0);
        issue_op(orq_pkg::OP_NEWER, '0);
        issue_op(orq_pkg::OP_READ, '0);
        issue_op(orq_pkg::OP_POP, '0);
        issue_op(orq_pkg::OP_POP, '0);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            cap_value = (phase >= 9) ? 5'($urandom_range(0, 31)) : 5'(cap_plan[phase]);
            set_capacity(cap_value);
            push_pct = $urandom_range(25, 70);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if ($urandom_range(0, 199) == 0)
                begin
                    wait_idle();
                end
                issue_op(random_op(push_pct), random_entry());
            end
        end

        s_axis_tvalid = 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (10) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
